// ===== rtl/core/rag_pkg.sv =====
// shared widths, constants and defaults for the ramped audio gain block
package rag_pkg;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int TARGET_W   = 17;
    localparam int LOUD_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int LEN_W      = 13;

    // ramp numerator d * index and its divider
    localparam int DIVIDEND_W = LOUD_W + INDEX_W;

    // shared multiplier operand and product widths
    localparam int OPND_W     = 24;
    localparam int PROD_W     = 2 * OPND_W;

    // q2.14 fixed point
    localparam int Q_FRAC     = 14;
    localparam int Q14_HALF   = 8192;
    localparam int TAPER_LIMIT = 1639;

    // block length defaults
    localparam int BLOCK_LENGTH_MAX_DEF = 4096;
    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = LEN_W'(512);

    // saturation limits of the output magnitude
    localparam logic [SAMPLE_W-1:0] MAG_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] MAG_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ===== rtl/core/rag_div.sv =====
// restoring divider, one quotient bit per cycle
module rag_div #(
    parameter int DIVIDEND_W = rag_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = rag_pkg::LEN_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[DIVISOR_W+1];

    // step counter and done pulse
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quotient shifts in from the right, remainder builds up
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/ramped_audio_gain.sv =====
// loudness control with quartic taper and linear gain ramp, top level
//
//  channel | direction | payload
//  s_      | in        | sample, target loudness, index; tlast = last of call
//  m_      | out       | gain-adjusted sample
//  cfg_    | in        | block length register
//
// steps from request to result: ramp multiply, divider start, 28 divider
// steps plus done, three or four multiply and round pairs on the one 24x24
// multiplier (four below the taper limit), output load; requests taken in idle.
// reset clears the sequencer, the output valid and the stored loudness
// (silence) and loads a block length of 512. a waiting result does not block
// the next request; the last step stalls only while the previous result waits.
module ramped_audio_gain #(
    parameter int BLOCK_LENGTH_MAX = rag_pkg::BLOCK_LENGTH_MAX_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // in_sample [23:0], target_loudness [40:24], sample_index [52:41], zero [55:53]
    input  logic [55:0]              s_tdata,
    input  logic                     s_tlast,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // out_sample [23:0]
    output logic [23:0]              m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // block_length [12:0]
    input  logic [rag_pkg::LEN_W-1:0] cfg_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready
);

    localparam int SW  = rag_pkg::SAMPLE_W;
    localparam int LW  = rag_pkg::LOUD_W;
    localparam int IW  = rag_pkg::INDEX_W;
    localparam int NW  = rag_pkg::LEN_W;
    localparam int OW  = rag_pkg::OPND_W;
    localparam int PW  = rag_pkg::PROD_W;
    localparam int RW  = PW - rag_pkg::Q_FRAC;
    localparam int DW  = rag_pkg::DIVIDEND_W;
    localparam int LEN_FULL = (1 << NW) - 1;
    localparam logic [NW-1:0] LEN_CAP =
        NW'((BLOCK_LENGTH_MAX > LEN_FULL) ? LEN_FULL : BLOCK_LENGTH_MAX);

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PROD  = 4'd1;
    localparam logic [3:0] ST_DIVST = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_MSQ   = 4'd4;
    localparam logic [3:0] ST_RSQ   = 4'd5;
    localparam logic [3:0] ST_MQ4   = 4'd6;
    localparam logic [3:0] ST_RQ4   = 4'd7;
    localparam logic [3:0] ST_R10   = 4'd8;
    localparam logic [3:0] ST_MTAP  = 4'd9;
    localparam logic [3:0] ST_RTAP  = 4'd10;
    localparam logic [3:0] ST_MSMP  = 4'd11;
    localparam logic [3:0] ST_RSMP  = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] blen_reg, blen_next;
    logic [LW-1:0] start_reg, start_next;
    logic          mvalid_reg, mvalid_next;
    logic [SW-1:0] mdata_reg;

    // per-item payload
    logic [SW-1:0] mag_reg;
    logic          neg_reg;
    logic [LW-1:0] tgt_reg;
    logic [IW-1:0] idx_reg;
    logic          last_reg;
    logic [LW-1:0] d_reg;
    logic          up_reg;
    logic [LW-1:0] v_reg;
    logic [OW-1:0] rnd_reg;
    logic [SW-1:0] sat_reg;
    logic [PW-1:0] prod_reg;

    logic [NW-1:0] len_eff;
    logic [SW-1:0] in_sample;
    logic [LW-1:0] tgt_in;
    logic          accept;
    logic          out_free;
    logic [OW-1:0] mul_a, mul_b;
    logic [PW-1:0] rnd_sum;
    logic [RW-1:0] rounded;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [LW-1:0] ramp_v;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !mvalid_reg || m_tready;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    // input fields, negative target clamps to zero
    assign in_sample = s_tdata[SW-1:0];
    assign tgt_in    = s_tdata[SW+LW] ? '0 : s_tdata[SW+LW-1:SW];

    // effective block length, zero acts as one, capped at BLOCK_LENGTH_MAX
    always_comb begin
        if (blen_reg == '0) begin
            len_eff = NW'(1);
        end else if (blen_reg > LEN_CAP) begin
            len_eff = LEN_CAP;
        end else begin
            len_eff = blen_reg;
        end
    end

    // divider for the ramp position
    rag_div #(
        .DIVIDEND_W(DW),
        .DIVISOR_W (NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIVST),
        .dividend(prod_reg[DW-1:0]),
        .divisor (len_eff),
        .done    (div_done),
        .quotient(div_quo)
    );

    // ramp value, saturated at the target past the block end
    always_comb begin
        if ({1'b0, idx_reg} >= len_eff) begin
            ramp_v = tgt_reg;
        end else if (up_reg) begin
            ramp_v = start_reg + div_quo[LW-1:0];
        end else begin
            ramp_v = start_reg - div_quo[LW-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PROD: begin
                mul_a = OW'(d_reg);
                mul_b = OW'(idx_reg);
            end
            ST_MSQ: begin
                mul_a = OW'(v_reg);
                mul_b = OW'(v_reg);
            end
            ST_MQ4: begin
                mul_a = rnd_reg;
                mul_b = rnd_reg;
            end
            ST_MTAP: begin
                mul_a = rnd_reg;
                mul_b = OW'(v_reg);
            end
            ST_MSMP: begin
                mul_a = mag_reg;
                mul_b = rnd_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // q14 rounding of the registered product
    assign rnd_sum = prod_reg + PW'(rag_pkg::Q14_HALF);
    assign rounded = rnd_sum[PW-1:rag_pkg::Q_FRAC];

    // sequencer
    always_comb begin
        state_next  = state_reg;
        blen_next   = blen_reg;
        start_next  = start_reg;
        mvalid_next = mvalid_reg;
        if (cfg_valid && cfg_ready) begin
            blen_next = cfg_data;
        end
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_PROD;
            ST_PROD:  state_next = ST_DIVST;
            ST_DIVST: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MSQ;
            ST_MSQ:   state_next = ST_RSQ;
            ST_RSQ:   state_next = ST_MQ4;
            ST_MQ4:   state_next = ST_RQ4;
            ST_RQ4: begin
                if (v_reg < LW'(rag_pkg::TAPER_LIMIT)) begin
                    state_next = ST_R10;
                end else begin
                    state_next = ST_MSMP;
                end
            end
            ST_R10:   state_next = ST_MTAP;
            ST_MTAP:  state_next = ST_RTAP;
            ST_RTAP:  state_next = ST_MSMP;
            ST_MSMP:  state_next = ST_RSMP;
            ST_RSMP:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                    if (last_reg) begin
                        start_next = tgt_reg;
                    end
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            blen_reg   <= rag_pkg::BLOCK_LENGTH_RESET;
            start_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            blen_reg   <= blen_next;
            start_reg  <= start_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (accept) begin
            neg_reg  <= in_sample[SW-1];
            mag_reg  <= in_sample[SW-1] ? (SW'(0) - in_sample) : in_sample;
            tgt_reg  <= tgt_in;
            idx_reg  <= s_tdata[SW+rag_pkg::TARGET_W+IW-1:SW+rag_pkg::TARGET_W];
            last_reg <= s_tlast;
            up_reg   <= (tgt_in >= start_reg);
            d_reg    <= (tgt_in >= start_reg) ? (tgt_in - start_reg)
                                              : (start_reg - tgt_in);
        end
        if (state_reg == ST_DIV && div_done) begin
            v_reg <= ramp_v;
        end
        case (state_reg) inside
            ST_RSQ, ST_RQ4, ST_RTAP: rnd_reg <= rounded[OW-1:0];
            ST_R10: rnd_reg <= (rnd_reg << 3) + (rnd_reg << 1);
            default: rnd_reg <= rnd_reg;
        endcase
        // saturate the magnitude by sign
        if (state_reg == ST_RSMP) begin
            if (neg_reg) begin
                sat_reg <= (rounded > RW'(rag_pkg::MAG_NEG_MAX)) ?
                           rag_pkg::MAG_NEG_MAX : rounded[SW-1:0];
            end else begin
                sat_reg <= (rounded > RW'(rag_pkg::MAG_POS_MAX)) ?
                           rag_pkg::MAG_POS_MAX : rounded[SW-1:0];
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            mdata_reg <= neg_reg ? (SW'(0) - sat_reg) : sat_reg;
        end
    end

endmodule

// ===== bench/tb.sv =====
// testbench for the ramped audio gain block: directed table, random calls, scoreboard
`timescale 1ns / 1ps

module tb;

    // package constants used here
    localparam int SAMPLE_W             = rag_pkg::SAMPLE_W;
    localparam int TARGET_W             = rag_pkg::TARGET_W;
    localparam int LOUD_W               = rag_pkg::LOUD_W;
    localparam int INDEX_W              = rag_pkg::INDEX_W;
    localparam int LEN_W                = rag_pkg::LEN_W;
    localparam int Q_FRAC               = rag_pkg::Q_FRAC;
    localparam int Q14_HALF             = rag_pkg::Q14_HALF;
    localparam int TAPER_LIMIT          = rag_pkg::TAPER_LIMIT;
    localparam int BLOCK_LENGTH_MAX_DEF = rag_pkg::BLOCK_LENGTH_MAX_DEF;
    localparam logic [LEN_W-1:0]    BLOCK_LENGTH_RESET = rag_pkg::BLOCK_LENGTH_RESET;
    localparam logic [SAMPLE_W-1:0] MAG_POS_MAX        = rag_pkg::MAG_POS_MAX;
    localparam logic [SAMPLE_W-1:0] MAG_NEG_MAX        = rag_pkg::MAG_NEG_MAX;

    localparam int DIR_N      = 24;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 600;
    localparam int DRAIN_WAIT = 200;
    localparam bit BY_MODEL   = 1'b0;
    localparam bit TYPED      = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic [TARGET_W-1:0] tgt;
        logic [INDEX_W-1:0]  idx;
        logic                last;
        logic                typed;
        logic [SAMPLE_W-1:0] want;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic [55:0]         s_tdata;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [LEN_W-1:0]    cfg_data;
    logic                cfg_valid;
    logic                cfg_ready;

    // predictor state
    logic [LOUD_W-1:0]   ramp_start;
    logic [LEN_W-1:0]    block_len;

    logic [SAMPLE_W-1:0] expected_samples[$];
    int                  mismatch_cnt;
    int                  idle_cycles;
    int                  nogap_left;
    bit                  rx_hold_req;
    dir_row_t            dir_tab [DIR_N];

    ramped_audio_gain u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // block length as the ramp divider sees it
    function automatic int unsigned eff_len();
        int unsigned len;
        len = block_len;
        if (len == 0) len = 1;
        if (len > BLOCK_LENGTH_MAX_DEF) len = BLOCK_LENGTH_MAX_DEF;
        return len;
    endfunction

    // expected gain-adjusted sample for one request
    function automatic logic [SAMPLE_W-1:0] scaled_sample(logic [SAMPLE_W-1:0] smp,
                                                          logic [TARGET_W-1:0] tgt,
                                                          logic [INDEX_W-1:0] idx);
        longint unsigned tv, sv, dv, qv, v, v2, v4, g, mag, m;
        int unsigned     len;
        bit              neg;
        len = eff_len();
        tv  = tgt[TARGET_W-1] ? 0 : tgt[LOUD_W-1:0];
        sv  = ramp_start;
        // linear ramp from the stored loudness, saturated past the block end
        if (idx >= len) begin
            v = tv;
        end else begin
            dv = (tv >= sv) ? tv - sv : sv - tv;
            qv = (dv * idx) / len;
            v  = (tv >= sv) ? sv + qv : sv - qv;
        end
        // quartic taper, extra 10v factor below 0.1
        v2 = (v * v + Q14_HALF) >> Q_FRAC;
        v4 = (v2 * v2 + Q14_HALF) >> Q_FRAC;
        g  = (v < TAPER_LIMIT) ? (v4 * 10 * v + Q14_HALF) >> Q_FRAC : v4;
        // scale magnitude, round half away from zero, saturate
        neg = smp[SAMPLE_W-1];
        mag = neg ? (64'h1000000 - smp) : smp;
        m   = (mag * g + Q14_HALF) >> Q_FRAC;
        if (neg)
            return (m > 64'd8388608) ? MAG_NEG_MAX : SAMPLE_W'(64'd0 - m);
        return (m > 64'd8388607) ? MAG_POS_MAX : SAMPLE_W'(m);
    endfunction

    // sender gap: bursts without gaps, mostly short gaps, a few long ones
    function automatic int next_gap();
        int r;
        if (nogap_left > 0) begin
            nogap_left--;
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 3) nogap_left = $urandom_range(5, 40);
        if (r < 8) return 0;
        if (r < 19) return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    // one request on the sample channel, expectation queued at acceptance
    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic [TARGET_W-1:0] tgt,
                               logic [INDEX_W-1:0] idx, logic last,
                               logic typed, logic [SAMPLE_W-1:0] want);
        int gap;
        @(negedge aclk);
        s_tdata  = {3'b000, idx, tgt, smp};
        s_tlast  = last;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_samples.push_back(typed ? want : scaled_sample(smp, tgt, idx));
        if (last) ramp_start = tgt[TARGET_W-1] ? '0 : tgt[LOUD_W-1:0];
        gap = next_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0) @(posedge aclk);
    endtask

    // block length write, only while idle
    task automatic write_block_len(logic [LEN_W-1:0] val);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        wait_drained();
        @(negedge aclk);
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        block_len = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return MAG_POS_MAX;
            1:       return MAG_NEG_MAX;
            2:       return SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [TARGET_W-1:0] pick_target();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return TARGET_W'(16384);
            2:       return TARGET_W'($urandom_range(0, TAPER_LIMIT));
            3:       return TARGET_W'($urandom);
            4:       return TARGET_W'($urandom_range(0, 65535));
            default: return TARGET_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // random stimulus: mostly whole calls of channel blocks, some noise
    task automatic random_phase(int n_items, bit long_hold, bit mid_pause);
        int                  sent;
        int                  n_blk;
        int                  run_len;
        int unsigned         len;
        int unsigned         step;
        int unsigned         idx;
        logic [TARGET_W-1:0] tgt;
        bit                  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (long_hold && sent >= n_items / 3 && !rx_hold_req && sent < n_items / 3 + 2)
                rx_hold_req = 1'b1;
            if (mid_pause && !paused && sent >= n_items / 2) begin
                paused = 1'b1;
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 9) < 7) begin
                len     = eff_len();
                tgt     = pick_target();
                n_blk   = $urandom_range(1, 3);
                run_len = $urandom_range(1, 10);
                if (run_len > len) run_len = len;
                step = len / run_len;
                for (int b = 0; b < n_blk; b++) begin
                    for (int k = 0; k < run_len; k++) begin
                        idx = k * step;
                        if (k != 0 && step > 1) idx += $urandom_range(0, step - 1);
                        if (idx >= len) idx = len - 1;
                        send_sample(pick_sample(), tgt, INDEX_W'(idx),
                                    (b == n_blk - 1) && (k == run_len - 1), BY_MODEL, '0);
                        sent++;
                    end
                end
            end else begin
                send_sample(SAMPLE_W'($urandom), TARGET_W'($urandom), INDEX_W'($urandom),
                            1'($urandom), BY_MODEL, '0);
                sent++;
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        int run_left;
        int hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req && hold_left == 0) begin
                hold_left   = HOLD_LEN;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready = 1'b1;
            end else begin
                run_left   = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                         : $urandom_range(0, 3);
                m_tready   = (stall_left == 0);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("out_sample: expected none, got %0d", $signed(m_tdata));
                mismatch_cnt++;
            end else begin
                if (m_tdata !== expected_samples[0]) begin
                    $error("out_sample: expected %0d, got %0d",
                           $signed(expected_samples[0]), $signed(m_tdata));
                    mismatch_cnt++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main sequence
    initial begin
        logic [LEN_W-1:0] len_list [11];
        aresetn      = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tvalid     = 1'b0;
        cfg_data     = '0;
        cfg_valid    = 1'b0;
        ramp_start   = '0;
        block_len    = BLOCK_LENGTH_RESET;
        mismatch_cnt = 0;
        idle_cycles  = 0;
        nogap_left   = 0;
        rx_hold_req  = 1'b0;

        // directed rows: sample, target, index, last, typed, expected
        // silence after reset, then extremes past the block end where v equals the target
        dir_tab[0]  = '{24'd1000,      17'd0,       12'd0,    1'b0, TYPED,    24'd0};
        dir_tab[1]  = '{24'h7FFFFF,    17'd16384,   12'd4095, 1'b0, TYPED,    24'h7FFFFF};
        dir_tab[2]  = '{24'h800000,    17'd16384,   12'd4095, 1'b0, TYPED,    24'h800000};
        dir_tab[3]  = '{24'h7FFFFF,    17'd32768,   12'd4095, 1'b0, TYPED,    24'h7FFFFF};
        dir_tab[4]  = '{24'h800000,    17'd32768,   12'd4095, 1'b0, TYPED,    24'h800000};
        dir_tab[5]  = '{24'd1,         17'd32768,   12'd4095, 1'b0, TYPED,    24'd16};
        dir_tab[6]  = '{24'hFFFFFF,    17'd32768,   12'd4095, 1'b0, TYPED,    24'hFFFFF0};
        // negative targets clamp to silence, then the largest positive target
        dir_tab[7]  = '{24'h7FFFFF,    17'h1FFFF,   12'd4095, 1'b0, TYPED,    24'd0};
        dir_tab[8]  = '{24'h7FFFFF,    17'h18000,   12'd100,  1'b0, TYPED,    24'd0};
        dir_tab[9]  = '{24'd1000,      17'd65535,   12'd4095, 1'b0, BY_MODEL, 24'd0};
        // ramp up from silence over a 512 block
        dir_tab[10] = '{24'h7FFFFF,    17'd16384,   12'd0,    1'b0, TYPED,    24'd0};
        dir_tab[11] = '{24'h7FFFFF,    17'd16384,   12'd256,  1'b0, BY_MODEL, 24'd0};
        dir_tab[12] = '{24'h7FFFFF,    17'd16384,   12'd511,  1'b0, BY_MODEL, 24'd0};
        dir_tab[13] = '{24'd12345,     17'd16384,   12'd512,  1'b0, TYPED,    24'd12345};
        // taper edge just below and at 0.1
        dir_tab[14] = '{24'h7FFFFF,    17'd1638,    12'd4095, 1'b0, BY_MODEL, 24'd0};
        dir_tab[15] = '{24'h7FFFFF,    17'd1639,    12'd4095, 1'b0, BY_MODEL, 24'd0};
        dir_tab[16] = '{24'd4000000,   17'd16384,   12'd511,  1'b1, BY_MODEL, 24'd0};
        // stored loudness now unity: flat ramp, then ramp down
        dir_tab[17] = '{24'd777777,    17'd16384,   12'd0,    1'b0, TYPED,    24'd777777};
        dir_tab[18] = '{24'd5000000,   17'd0,       12'd256,  1'b0, BY_MODEL, 24'd0};
        dir_tab[19] = '{24'd5000000,   17'd0,       12'd0,    1'b0, TYPED,    24'd5000000};
        dir_tab[20] = '{24'h000100,    17'd65535,   12'd4095, 1'b1, BY_MODEL, 24'd0};
        dir_tab[21] = '{24'hFFEC78,    17'h10000,   12'd2048, 1'b0, BY_MODEL, 24'd0};
        dir_tab[22] = '{24'd3,         17'd0,       12'd0,    1'b1, BY_MODEL, 24'd0};
        dir_tab[23] = '{24'd0,         17'd32768,   12'd4095, 1'b0, TYPED,    24'd0};

        len_list = '{13'd0, 13'd1, 13'd8191, 13'd4096, 13'd4097, 13'd3, 13'd16,
                     13'd37, 13'd512, 13'd4095, 13'd0};
        len_list[10] = LEN_W'($urandom_range(2, 300));

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_sample(dir_tab[i].smp, dir_tab[i].tgt, dir_tab[i].idx, dir_tab[i].last,
                        dir_tab[i].typed, dir_tab[i].want);

        for (int p = 0; p < 11; p++) begin
            write_block_len(len_list[p]);
            random_phase(120, p == 2, p == 5);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rag_pkg.sv
rtl/core/rag_div.sv
rtl/core/ramped_audio_gain.sv
bench/tb.sv
